>>> rtl/hcbd_pkg.sv
// Shared types and constants for the chunked body decoder.
package hcbd_pkg;

  localparam int BYTE_W      = 8;
  localparam int SIZE_W      = 32;
  localparam int COUNT_W     = 4;
  localparam int SIZE_DIGITS = 8;

  // Flags carried in tuser, from the lowest bit up
  localparam int USER_W       = 3;
  localparam int USER_PAYLOAD = 0;
  localparam int USER_DONE    = 1;
  localparam int USER_ERROR   = 2;

  typedef struct packed {
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              chunk_last;
    logic              body_done;
    logic              format_error;
  } hcbd_result_t;

endpackage

>>> rtl/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked transfer body decoder.
// Feed the raw body bytes, starting with the first chunk-size line, one item per
// byte; every input item yields exactly one result item. The block sustains one
// item per clock while m_tready does not stall the result register: the parse
// state (phase, remaining size, digit count) is updated combinationally as an
// item moves from the input register into the result register.
// Results carry the payload byte in tdata, payload/done/error flags in tuser and
// the last byte of each chunk on tlast. After an error or the end of a body the
// decoder waits for a new size line.
module http_chunked_body_decoder #(
  parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input items
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [hcbd_pkg::BYTE_W-1:0] s_tdata,  // [7:0] data_byte
  // Result items
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [hcbd_pkg::BYTE_W-1:0] m_tdata,  // [7:0] payload_byte
  output logic                        m_tlast,  // chunk_last
  output logic [hcbd_pkg::USER_W-1:0] m_tuser   // [0] payload_valid, [1] body_done,
                                                // [2] format_error
);
  import hcbd_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_ready;
  logic              advance;
  hcbd_result_t      res;

  assign out_ready = !m_tvalid || m_tready;
  assign advance   = in_valid && out_ready;
  assign s_tready  = !in_valid || out_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  hcbd_parse #(
    .SIZE_DIGITS(SIZE_DIGITS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .data_byte(in_byte),
    .res      (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata               <= res.payload_byte;
      m_tlast               <= res.chunk_last;
      m_tuser[USER_PAYLOAD] <= res.payload_valid;
      m_tuser[USER_DONE]    <= res.body_done;
      m_tuser[USER_ERROR]   <= res.format_error;
    end
  end

endmodule

>>> rtl/hcbd_parse.sv
// Chunked body parse state and per-byte result logic.
module hcbd_parse #(
  parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [hcbd_pkg::BYTE_W-1:0] data_byte,
  output hcbd_pkg::hcbd_result_t      res
);
  import hcbd_pkg::*;

  localparam logic [3:0] PH_SIZE     = 4'd0;
  localparam logic [3:0] PH_EXT      = 4'd1;
  localparam logic [3:0] PH_SIZE_LF  = 4'd2;
  localparam logic [3:0] PH_DATA     = 4'd3;
  localparam logic [3:0] PH_DATA_CR  = 4'd4;
  localparam logic [3:0] PH_DATA_LF  = 4'd5;
  localparam logic [3:0] PH_TR_START = 4'd6;
  localparam logic [3:0] PH_TR_TEXT  = 4'd7;
  localparam logic [3:0] PH_TR_LF    = 4'd8;
  localparam logic [3:0] PH_FINAL_LF = 4'd9;

  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;

  localparam logic [COUNT_W-1:0] MAX_DIGITS = COUNT_W'(SIZE_DIGITS);

  logic [3:0]         phase, phase_next;
  logic [SIZE_W-1:0]  remaining, remaining_next;
  logic [COUNT_W-1:0] digits, digits_next;

  logic       is_hex;
  logic [3:0] hex_val;

  // Hex digit decode, both cases
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      hex_val = data_byte[3:0];
    end else if ((data_byte >= 8'h41 && data_byte <= 8'h46) ||
                 (data_byte >= 8'h61 && data_byte <= 8'h66)) begin
      hex_val = 4'(data_byte[2:0] + 3'd1) + 4'd8;
    end else begin
      is_hex = 1'b0;
    end
  end

  // Next state and result for the current byte
  always_comb begin
    logic err;
    err            = 1'b0;
    phase_next     = phase;
    remaining_next = remaining;
    digits_next    = digits;
    res            = '0;
    case (phase)
      PH_SIZE: begin
        if (is_hex) begin
          if (digits >= MAX_DIGITS || remaining[SIZE_W-1 -: 4] != 4'd0) begin
            err = 1'b1;
          end else begin
            remaining_next = {remaining[SIZE_W-5:0], hex_val};
            digits_next    = digits + COUNT_W'(1);
          end
        end else if (digits == '0) begin
          err = 1'b1;
        end else if (data_byte == CH_CR) begin
          phase_next = PH_SIZE_LF;
        end else if (data_byte == CH_SEMI || data_byte == CH_SP || data_byte == CH_TAB) begin
          phase_next = PH_EXT;
        end else begin
          err = 1'b1;
        end
      end
      PH_EXT: begin
        if (data_byte == CH_CR) phase_next = PH_SIZE_LF;
      end
      PH_SIZE_LF: begin
        if (data_byte != CH_LF) begin
          err = 1'b1;
        end else begin
          digits_next = '0;
          phase_next  = (remaining == '0) ? PH_TR_START : PH_DATA;
        end
      end
      PH_DATA: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = data_byte;
        if (remaining <= SIZE_W'(1)) begin
          remaining_next = '0;
          res.chunk_last = 1'b1;
          phase_next     = PH_DATA_CR;
        end else begin
          remaining_next = remaining - SIZE_W'(1);
        end
      end
      PH_DATA_CR: begin
        if (data_byte == CH_CR) phase_next = PH_DATA_LF;
        else err = 1'b1;
      end
      PH_DATA_LF: begin
        if (data_byte == CH_LF) begin
          phase_next     = PH_SIZE;
          remaining_next = '0;
          digits_next    = '0;
        end else begin
          err = 1'b1;
        end
      end
      PH_TR_START: begin
        phase_next = (data_byte == CH_CR) ? PH_FINAL_LF : PH_TR_TEXT;
      end
      PH_TR_TEXT: begin
        if (data_byte == CH_CR) phase_next = PH_TR_LF;
      end
      PH_TR_LF: begin
        if (data_byte == CH_LF) phase_next = PH_TR_START;
        else err = 1'b1;
      end
      PH_FINAL_LF: begin
        if (data_byte == CH_LF) begin
          res.body_done  = 1'b1;
          phase_next     = PH_SIZE;
          remaining_next = '0;
          digits_next    = '0;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase
    // Any error drops back to waiting for a fresh size line
    if (err) begin
      phase_next     = PH_SIZE;
      remaining_next = '0;
      digits_next    = '0;
    end
    res.format_error = err;
  end

  // Parse state advances once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SIZE;
      remaining <= '0;
      digits    <= '0;
    end else if (step) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      digits    <= digits_next;
    end
  end

endmodule

>>> rtl/hcbd_check.sv
// Port-level checks for the chunked body decoder, bound to the top level.
module hcbd_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [hcbd_pkg::BYTE_W-1:0] m_tdata,
  input logic                        m_tlast,
  input logic [hcbd_pkg::USER_W-1:0] m_tuser
);
  import hcbd_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

  // At most one of payload, done and error per result
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(m_tuser) <= 1)
    else $error("conflicting result flags");

  // Chunk end only on a payload byte
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[USER_PAYLOAD])
    else $error("chunk_last without payload");

  // Non-payload results carry a zero byte
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[USER_PAYLOAD] |-> m_tdata == '0)
    else $error("nonzero byte on non-payload result");

  // With no pending input item the decoder is ready for the next one
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !$past(s_tvalid && s_tready) |-> s_tready)
    else $error("input stalled with empty pipeline");

endmodule

bind http_chunked_body_decoder hcbd_check u_hcbd_check (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast),
  .m_tuser (m_tuser)
);
